FILE: src/pwmrb_pkg.sv
// Package for the sixteen-channel PWM register block.
// Holds the sizing constants, register map, transaction types and controller types.
// Has no dependencies; every other file imports it.
package pwmrb_pkg;

    // Sizing.
    localparam int NUM_CHANNELS = 16;
    localparam int COUNT_BITS   = 12;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int OUT_BITS     = 16;
    localparam int CNT_W        = 13;

    // Register map.
    localparam logic [7:0] ADDR_MODE1    = 8'h00;
    localparam logic [7:0] ADDR_MODE2    = 8'h01;
    localparam logic [7:0] ADDR_ALIAS_LO = 8'h02;
    localparam logic [7:0] ADDR_ALIAS_HI = 8'h05;
    localparam logic [7:0] CH_BASE       = 8'h06;
    localparam logic [7:0] CH_END        = 8'(6 + 4 * NUM_CHANNELS);
    localparam logic [7:0] ALL_BASE      = 8'hFA;
    localparam logic [7:0] ALL_LAST      = 8'hFD;
    localparam logic [7:0] PRESCALE_ADDR = 8'hFE;

    // Byte positions inside one channel's four registers.
    localparam logic [1:0] SUB_ON_L  = 2'd0;
    localparam logic [1:0] SUB_ON_H  = 2'd1;
    localparam logic [1:0] SUB_OFF_L = 2'd2;
    localparam logic [1:0] SUB_OFF_H = 2'd3;

    // Bit positions and limits.
    localparam int FULL_IDX   = 12;
    localparam int SLEEP_IDX  = 4;
    localparam int INVRT_IDX  = 4;
    localparam int OUTDRV_IDX = 2;
    localparam logic [7:0] PRESCALE_FLOOR = 8'h03;

    // Output-disable behavior from mode two bits 1:0.
    localparam logic [1:0] OUTNE_LOW  = 2'd0;
    localparam logic [1:0] OUTNE_HIGH = 2'd1;

    // Reset values.
    localparam logic [7:0]       MODE1_RST    = 8'h11;
    localparam logic [4:0]       MODE2_RST    = 5'h04;
    localparam logic [7:0]       ALIAS0_RST   = 8'hE2;
    localparam logic [7:0]       ALIAS1_RST   = 8'hE4;
    localparam logic [7:0]       ALIAS2_RST   = 8'hE8;
    localparam logic [7:0]       ALIAS3_RST   = 8'hE0;
    localparam logic [7:0]       PRESCALE_RST = 8'h1E;
    localparam logic [CNT_W-1:0] ON_RST       = 13'h0000;
    localparam logic [CNT_W-1:0] OFF_RST      = 13'h1000;

    // Kind of transaction on the input channel.
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       outputs_disabled;
    } t_in_item;

    typedef struct packed {
        logic [7:0]          read_data;
        logic [OUT_BITS-1:0] pwm_level;
        logic [OUT_BITS-1:0] pwm_driven;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic capture;
    } t_ctrl_cmd;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESULT = 1'b1
    } t_state;

endpackage

FILE: src/pwmrb_ctrl.sv
// Controller for the PWM register block: handshakes and the two-step sequence.
// Depends on pwmrb_pkg for the command struct and state type.
module pwmrb_ctrl
    import pwmrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.exec    = 1'b0;
        o_cmd.capture = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.exec = i_in_valid;
            end
            ST_RESULT: begin
                o_cmd.capture = out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // Result valid is set on capture and held until the transaction completes.
    assign n_out_valid = o_cmd.capture || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_exec_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == ST_RESULT))
        else $error("accepted transaction did not move to result state");

    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_out_valid)
        else $error("captured result not presented");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && r_out_valid && i_out_stall) |=> (r_state == ST_RESULT))
        else $error("result overwritten while previous one was stalled");
`endif

endmodule

FILE: src/pwmrb_dp.sv
// Datapath for the PWM register block: register file, prescale divider,
// period counter, channel comparators and the result register. Uses pwmrb_pkg.
module pwmrb_dp
    import pwmrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    input  t_in_item  i_in_data,
    output t_out_item o_out_data
);

    logic [7:0]            r_mode_one,  n_mode_one;
    logic [4:0]            r_mode_two,  n_mode_two;
    logic [7:0]            r_alias      [4];
    logic [7:0]            n_alias      [4];
    logic [7:0]            r_prescale,  n_prescale;
    logic [7:0]            r_divider,   n_divider;
    logic [COUNT_BITS-1:0] r_counter,   n_counter;
    logic [CNT_W-1:0]      r_on         [NUM_CHANNELS];
    logic [CNT_W-1:0]      n_on         [NUM_CHANNELS];
    logic [CNT_W-1:0]      r_off        [NUM_CHANNELS];
    logic [CNT_W-1:0]      n_off        [NUM_CHANNELS];
    logic [7:0]            r_rd,        n_rd;
    logic                  r_disabled,  n_disabled;
    t_out_item             r_out;

    logic [7:0]       addr;
    logic [7:0]       data;
    logic [7:0]       chan_off;
    logic             chan_hit;
    logic             all_hit;
    logic [1:0]       sub;
    logic [CH_W-1:0]  ch_sel;
    logic [1:0]       alias_sel;
    logic [CNT_W-1:0] rd_count;
    logic [7:0]       rd_byte;
    logic [OUT_BITS-1:0] level;
    logic [OUT_BITS-1:0] driven;

    // Compare window of one channel against the period counter.
    function automatic logic chan_level(
        input logic [CNT_W-1:0]      on,
        input logic [CNT_W-1:0]      off,
        input logic [COUNT_BITS-1:0] cnt
    );
        logic [COUNT_BITS-1:0] on_c;
        logic [COUNT_BITS-1:0] off_c;
        logic                  lv;
        on_c  = on[COUNT_BITS-1:0];
        off_c = off[COUNT_BITS-1:0];
        priority if (on[FULL_IDX]) begin
            lv = 1'b1;
        end else if (off[FULL_IDX]) begin
            lv = 1'b0;
        end else if (on_c < off_c) begin
            lv = (cnt >= on_c) && (cnt < off_c);
        end else if (on_c > off_c) begin
            lv = (cnt >= on_c) || (cnt < off_c);
        end else begin
            lv = 1'b0;
        end
        return lv;
    endfunction

    // Address decode.
    assign addr      = i_in_data.reg_addr;
    assign data      = i_in_data.write_data;
    assign chan_off  = addr - CH_BASE;
    assign chan_hit  = (addr >= CH_BASE) && (addr < CH_END);
    assign all_hit   = (addr >= ALL_BASE) && (addr <= ALL_LAST);
    assign sub       = chan_hit ? chan_off[1:0] : (addr[1:0] - ALL_BASE[1:0]);
    assign ch_sel    = chan_off[CH_W+1:2];
    assign alias_sel = addr[1:0] - ADDR_ALIAS_LO[1:0];

    // Read mux over the register map.
    always_comb begin
        rd_count = (sub == SUB_OFF_L || sub == SUB_OFF_H) ? r_off[ch_sel] : r_on[ch_sel];
        priority if (addr == ADDR_MODE1) begin
            rd_byte = r_mode_one;
        end else if (addr == ADDR_MODE2) begin
            rd_byte = {3'b000, r_mode_two};
        end else if (addr >= ADDR_ALIAS_LO && addr <= ADDR_ALIAS_HI) begin
            rd_byte = r_alias[alias_sel];
        end else if (chan_hit) begin
            rd_byte = (sub == SUB_ON_H || sub == SUB_OFF_H) ?
                      {3'b000, rd_count[CNT_W-1:8]} : rd_count[7:0];
        end else if (addr == PRESCALE_ADDR) begin
            rd_byte = r_prescale;
        end else begin
            rd_byte = 8'h00;
        end
    end

    // Next-state logic for one accepted transaction.
    always_comb begin
        n_mode_one = r_mode_one;
        n_mode_two = r_mode_two;
        n_alias    = r_alias;
        n_prescale = r_prescale;
        n_divider  = r_divider;
        n_counter  = r_counter;
        n_on       = r_on;
        n_off      = r_off;
        n_rd       = r_rd;
        n_disabled = r_disabled;
        if (i_cmd.exec) begin
            n_rd       = 8'h00;
            n_disabled = i_in_data.outputs_disabled;
            unique case (i_in_data.action)
                ACT_WRITE: begin
                    priority if (addr == ADDR_MODE1) begin
                        n_mode_one = data;
                    end else if (addr == ADDR_MODE2) begin
                        n_mode_two = data[4:0];
                    end else if (addr >= ADDR_ALIAS_LO && addr <= ADDR_ALIAS_HI) begin
                        n_alias[alias_sel] = data;
                    end else if (addr == PRESCALE_ADDR) begin
                        if (r_mode_one[SLEEP_IDX]) begin
                            n_prescale = (data < PRESCALE_FLOOR) ? PRESCALE_FLOOR : data;
                        end
                    end else begin
                        // Channel and all-channel writes share the byte placement.
                        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                            if ((chan_hit && ch_sel == CH_W'(ch)) || all_hit) begin
                                unique case (sub)
                                    SUB_ON_L:  n_on[ch][7:0]        = data;
                                    SUB_ON_H:  n_on[ch][CNT_W-1:8]  = data[4:0];
                                    SUB_OFF_L: n_off[ch][7:0]       = data;
                                    SUB_OFF_H: n_off[ch][CNT_W-1:8] = data[4:0];
                                    default:   n_on[ch]             = r_on[ch];
                                endcase
                            end
                        end
                    end
                end
                ACT_READ: begin
                    n_rd = rd_byte;
                end
                ACT_TICK: begin
                    if (!r_mode_one[SLEEP_IDX]) begin
                        if (r_divider >= r_prescale) begin
                            n_divider = 8'h00;
                            n_counter = r_counter + 1'b1;
                        end else begin
                            n_divider = r_divider + 8'h01;
                        end
                    end
                end
                ACT_NONE: begin
                    n_rd = 8'h00;
                end
                default: n_rd = 8'h00;
            endcase
        end
    end

    // Channel outputs from the updated state.
    always_comb begin
        level  = '0;
        driven = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (r_disabled) begin
                if (r_mode_two[1:0] == OUTNE_LOW) begin
                    driven[ch] = 1'b1;
                end else if (r_mode_two[1:0] == OUTNE_HIGH && r_mode_two[OUTDRV_IDX]) begin
                    level[ch]  = 1'b1;
                    driven[ch] = 1'b1;
                end
            end else begin
                if (r_mode_two[OUTDRV_IDX]) begin
                    level[ch]  = chan_level(r_on[ch], r_off[ch], r_counter)
                                 ^ r_mode_two[INVRT_IDX];
                    driven[ch] = 1'b1;
                end else begin
                    driven[ch] = !(chan_level(r_on[ch], r_off[ch], r_counter)
                                   ^ r_mode_two[INVRT_IDX]);
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_one <= MODE1_RST;
            r_mode_two <= MODE2_RST;
            r_alias[0] <= ALIAS0_RST;
            r_alias[1] <= ALIAS1_RST;
            r_alias[2] <= ALIAS2_RST;
            r_alias[3] <= ALIAS3_RST;
            r_prescale <= PRESCALE_RST;
            r_divider  <= 8'h00;
            r_counter  <= '0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r_on[ch]  <= ON_RST;
                r_off[ch] <= OFF_RST;
            end
        end else begin
            r_mode_one <= n_mode_one;
            r_mode_two <= n_mode_two;
            r_alias    <= n_alias;
            r_prescale <= n_prescale;
            r_divider  <= n_divider;
            r_counter  <= n_counter;
            r_on       <= n_on;
            r_off      <= n_off;
        end
    end

    // Per-transaction payload and the result register.
    always_ff @(posedge i_clk) begin
        r_rd       <= n_rd;
        r_disabled <= n_disabled;
        if (i_cmd.capture) begin
            r_out.read_data  <= r_rd;
            r_out.pwm_level  <= level;
            r_out.pwm_driven <= driven;
        end
    end

    assign o_out_data = r_out;

`ifndef ASSERT_OFF
    a_prescale_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prescale >= PRESCALE_FLOOR)
        else $error("prescale below minimum");

    a_sleep_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && i_in_data.action == ACT_TICK && r_mode_one[SLEEP_IDX])
        |=> ($stable(r_counter) && $stable(r_divider)))
        else $error("counter advanced while sleeping");

    a_read_byte_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && i_in_data.action != ACT_READ) |=> (r_rd == 8'h00))
        else $error("read byte nonzero for a transaction that is not a read");
`endif

endmodule

FILE: src/sixteen_channel_pwm_register_block_core.sv
// Top level of the sixteen-channel PWM register block.
// Instantiates pwmrb_ctrl and pwmrb_dp; types and constants come from pwmrb_pkg.
//
// Each input transaction is a register write, a register read or one oscillator tick,
// and it yields one result transaction with the read byte and the level and drive state
// of every channel after the access. A transaction runs in two steps: first the
// controller applies the access or tick to the register file, divider and period
// counter, then the channel comparators are evaluated into the result register, which
// waits while the previous result is still stalled. Input stays stalled until then, but
// the next input transaction is accepted while a finished result still waits to be taken.
module sixteen_channel_pwm_register_block_core
    import pwmrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_ctrl_cmd cmd;

    // Handshake and sequencing.
    pwmrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Registers, counters and channel outputs.
    pwmrb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

FILE: bench/tb_sixteen_channel_pwm_register_block_core.sv
// Testbench for sixteen_channel_pwm_register_block_core: register access, PWM outputs, flow.
// Depends on pwmrb_pkg for the transaction types, register map and reset values.
// A shadow copy of the register file predicts every result transaction in order.
`timescale 1ns / 1ps

module tb_sixteen_channel_pwm_register_block_core
    import pwmrb_pkg::*;
();

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    sixteen_channel_pwm_register_block_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow register file and PWM timebase.
    logic [7:0]            sh_mode_one;
    logic [7:0]            sh_mode_two;
    logic [7:0]            sh_addr_alias [4];
    logic [7:0]            sh_prescale;
    logic [7:0]            sh_divider;
    logic [COUNT_BITS-1:0] sh_counter;
    logic [CNT_W-1:0]      sh_on  [NUM_CHANNELS];
    logic [CNT_W-1:0]      sh_off [NUM_CHANNELS];

    t_out_item   pending_outputs[$];
    int unsigned err_count   = 0;
    bit          in_idle_on  = 1'b1;
    bit          out_idle_on = 1'b1;
    int unsigned hold_len    = 0;

    function automatic void shadow_reset();
        sh_mode_one      = MODE1_RST;
        sh_mode_two      = {3'b000, MODE2_RST};
        sh_addr_alias[0] = ALIAS0_RST;
        sh_addr_alias[1] = ALIAS1_RST;
        sh_addr_alias[2] = ALIAS2_RST;
        sh_addr_alias[3] = ALIAS3_RST;
        sh_prescale      = PRESCALE_RST;
        sh_divider       = '0;
        sh_counter       = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            sh_on[ch]  = ON_RST;
            sh_off[ch] = OFF_RST;
        end
    endfunction

    function automatic void set_channel_byte(int ch, logic [1:0] sub, logic [7:0] v);
        case (sub)
            SUB_ON_L:  sh_on[ch][7:0]         = v;
            SUB_ON_H:  sh_on[ch][FULL_IDX:8]  = v[4:0];
            SUB_OFF_L: sh_off[ch][7:0]        = v;
            default:   sh_off[ch][FULL_IDX:8] = v[4:0];
        endcase
    endfunction

    function automatic void write_register(logic [7:0] a, logic [7:0] v);
        logic [7:0] offs;
        offs = a - CH_BASE;
        if (a == ADDR_MODE1) begin
            sh_mode_one = v;
        end else if (a == ADDR_MODE2) begin
            sh_mode_two = {3'b000, v[4:0]};
        end else if (a >= ADDR_ALIAS_LO && a <= ADDR_ALIAS_HI) begin
            sh_addr_alias[2'(a - ADDR_ALIAS_LO)] = v;
        end else if (a >= CH_BASE && a < CH_END) begin
            set_channel_byte(int'(offs[7:2]), offs[1:0], v);
        end else if (a >= ALL_BASE && a <= ALL_LAST) begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
                set_channel_byte(ch, 2'(a - ALL_BASE), v);
        end else if (a == PRESCALE_ADDR && sh_mode_one[SLEEP_IDX]) begin
            sh_prescale = (v < PRESCALE_FLOOR) ? PRESCALE_FLOOR : v;
        end
    endfunction

    function automatic logic [7:0] read_register(logic [7:0] a);
        logic [7:0]       offs;
        logic [CNT_W-1:0] cnt;
        offs = a - CH_BASE;
        if (a == ADDR_MODE1)
            return sh_mode_one;
        if (a == ADDR_MODE2)
            return sh_mode_two;
        if (a >= ADDR_ALIAS_LO && a <= ADDR_ALIAS_HI)
            return sh_addr_alias[2'(a - ADDR_ALIAS_LO)];
        if (a >= CH_BASE && a < CH_END) begin
            cnt = offs[1] ? sh_off[offs[5:2]] : sh_on[offs[5:2]];
            return offs[0] ? {3'b000, cnt[FULL_IDX:8]} : cnt[7:0];
        end
        if (a == PRESCALE_ADDR)
            return sh_prescale;
        return 8'h00;
    endfunction

    // Level of one channel before inversion and drive mode.
    function automatic logic channel_high(int ch);
        logic [COUNT_BITS-1:0] on_v, off_v;
        if (sh_on[ch][FULL_IDX])
            return 1'b1;
        if (sh_off[ch][FULL_IDX])
            return 1'b0;
        on_v  = sh_on[ch][COUNT_BITS-1:0];
        off_v = sh_off[ch][COUNT_BITS-1:0];
        if (on_v < off_v)
            return sh_counter >= on_v && sh_counter < off_v;
        if (on_v > off_v)
            return sh_counter >= on_v || sh_counter < off_v;
        return 1'b0;
    endfunction

    // Applies one input transaction to the shadow state and returns its result.
    function automatic t_out_item predict_outputs(t_in_item it);
        t_out_item  res;
        logic [1:0] outne;
        logic       lv, drv, totem;
        res = '0;
        case (it.action)
            ACT_WRITE: write_register(it.reg_addr, it.write_data);
            ACT_READ:  res.read_data = read_register(it.reg_addr);
            ACT_TICK: begin
                if (!sh_mode_one[SLEEP_IDX]) begin
                    if (sh_divider >= sh_prescale) begin
                        sh_divider = '0;
                        sh_counter = sh_counter + 1'b1;
                    end else begin
                        sh_divider = sh_divider + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        totem = sh_mode_two[OUTDRV_IDX];
        outne = sh_mode_two[1:0];
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (it.outputs_disabled) begin
                if (outne == OUTNE_LOW) begin
                    lv  = 1'b0;
                    drv = 1'b1;
                end else if (outne == OUTNE_HIGH && totem) begin
                    lv  = 1'b1;
                    drv = 1'b1;
                end else begin
                    lv  = 1'b0;
                    drv = 1'b0;
                end
            end else begin
                lv  = channel_high(ch) ^ sh_mode_two[INVRT_IDX];
                drv = totem ? 1'b1 : !lv;
                if (!totem)
                    lv = 1'b0;
            end
            res.pwm_level[ch]  = lv;
            res.pwm_driven[ch] = drv;
        end
        return res;
    endfunction

    function automatic t_in_item make_item(t_action act, logic [7:0] a, logic [7:0] d,
                                           logic dis);
        t_in_item it;
        it.action           = act;
        it.reg_addr         = a;
        it.write_data       = d;
        it.outputs_disabled = dis;
        return it;
    endfunction

    // High bytes mostly keep counts low so the windows overlap the running counter.
    function automatic logic [7:0] channel_data(logic [1:0] sub);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (sub == SUB_ON_L || sub == SUB_OFF_L)
            return pick < 60 ? 8'($urandom_range(0, 127)) : 8'($urandom);
        if (pick < 65)
            return 8'h00;
        if (pick < 80)
            return 8'h10;
        return 8'($urandom);
    endfunction

    // One random transaction, weighted toward ticks and channel writes.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        logic [1:0]  sub;
        it = make_item(ACT_TICK, 8'($urandom), 8'($urandom), $urandom_range(0, 6) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.action = ACT_TICK;
        end else if (pick < 65) begin
            it.action     = ACT_WRITE;
            it.reg_addr   = CH_BASE + 8'($urandom_range(0, 4 * NUM_CHANNELS - 1));
            sub           = 2'(it.reg_addr - CH_BASE);
            it.write_data = channel_data(sub);
        end else if (pick < 70) begin
            it.action     = ACT_WRITE;
            sub           = 2'($urandom_range(0, 3));
            it.reg_addr   = ALL_BASE + 8'(sub);
            it.write_data = channel_data(sub);
        end else if (pick < 82) begin
            it.action = ACT_READ;
            if ($urandom_range(0, 9) < 7)
                it.reg_addr = 8'($urandom_range(0, int'(CH_END) - 1));
            else if ($urandom_range(0, 3) == 0)
                it.reg_addr = PRESCALE_ADDR;
        end else if (pick < 88) begin
            it.action   = ACT_WRITE;
            it.reg_addr = ADDR_MODE2;
        end else if (pick < 92) begin
            it.action   = ACT_WRITE;
            it.reg_addr = ADDR_MODE1;
            if ($urandom_range(0, 3) != 0)
                it.write_data[SLEEP_IDX] = 1'b0;
        end else if (pick < 95) begin
            it.action   = ACT_WRITE;
            it.reg_addr = ADDR_ALIAS_LO + 8'($urandom_range(0, 3));
        end else if (pick < 98) begin
            it.action = ACT_WRITE;
        end else begin
            it.action = ACT_NONE;
        end
        return it;
    endfunction

    // Offers one transaction, waits for it to be taken and records its result.
    task automatic send_item(input t_in_item it);
        if (in_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_outputs.push_back(predict_outputs(it));
    endtask

    task automatic note_error(input string what, input logic [15:0] want,
                              input logic [15:0] got);
        err_count++;
        if (err_count <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Result side: random stall bursts, or one long hold-off when requested.
    initial begin : out_side
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_out_stall <= 1'b0;
            end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Every accepted result transaction is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                note_error("unexpected result", 16'h0, 16'(o_out_data.read_data));
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_data.read_data !== want.read_data)
                    note_error("read_data", 16'(want.read_data), 16'(o_out_data.read_data));
                if (o_out_data.pwm_level !== want.pwm_level)
                    note_error("pwm_level", want.pwm_level, o_out_data.pwm_level);
                if (o_out_data.pwm_driven !== want.pwm_driven)
                    note_error("pwm_driven", want.pwm_driven, o_out_data.pwm_driven);
            end
        end
    end

    // Reset values of every register kind, plus all-channel and unused addresses.
    task automatic test_reset_values();
        send_item(make_item(ACT_READ, ADDR_MODE1, 8'hFF, 1'b0));
        send_item(make_item(ACT_READ, ADDR_MODE2, 8'h00, 1'b0));
        send_item(make_item(ACT_READ, ADDR_ALIAS_LO, 8'h00, 1'b0));
        send_item(make_item(ACT_READ, ADDR_ALIAS_HI, 8'h00, 1'b0));
        send_item(make_item(ACT_READ, CH_BASE, 8'h00, 1'b0));
        send_item(make_item(ACT_READ, CH_BASE + 8'd3, 8'h00, 1'b0));
        send_item(make_item(ACT_READ, PRESCALE_ADDR, 8'h00, 1'b0));
        send_item(make_item(ACT_READ, ALL_BASE, 8'h00, 1'b0));
        send_item(make_item(ACT_READ, 8'hFF, 8'h00, 1'b0));
    endtask

    // Prescale clamp while asleep, prescale ignored while awake, mode two masking.
    task automatic test_register_rules();
        send_item(make_item(ACT_WRITE, PRESCALE_ADDR, 8'h00, 1'b0));
        send_item(make_item(ACT_READ, PRESCALE_ADDR, 8'h00, 1'b0));
        send_item(make_item(ACT_WRITE, ADDR_MODE2, 8'hFF, 1'b0));
        send_item(make_item(ACT_READ, ADDR_MODE2, 8'h00, 1'b0));
        send_item(make_item(ACT_WRITE, ADDR_MODE1, 8'h01, 1'b0));
        send_item(make_item(ACT_WRITE, PRESCALE_ADDR, 8'hFF, 1'b0));
        send_item(make_item(ACT_READ, PRESCALE_ADDR, 8'h00, 1'b0));
        send_item(make_item(ACT_WRITE, CH_END, 8'hFF, 1'b0));
    endtask

    // Full-on and full-off flags, inversion, open drain and the disable pin modes.
    task automatic test_output_modes();
        send_item(make_item(ACT_WRITE, ALL_BASE + 8'd3, 8'h00, 1'b0));
        send_item(make_item(ACT_WRITE, CH_BASE + 8'd1, 8'h10, 1'b0));
        send_item(make_item(ACT_WRITE, CH_END - 8'd2, 8'h02, 1'b0));
        send_item(make_item(ACT_WRITE, ADDR_MODE2, 8'h04, 1'b1));
        send_item(make_item(ACT_TICK, 8'h00, 8'h00, 1'b1));
        send_item(make_item(ACT_WRITE, ADDR_MODE2, 8'h15, 1'b0));
        send_item(make_item(ACT_NONE, 8'h00, 8'h00, 1'b1));
        send_item(make_item(ACT_TICK, 8'h00, 8'h00, 1'b0));
        send_item(make_item(ACT_WRITE, ADDR_MODE2, 8'h01, 1'b1));
        send_item(make_item(ACT_TICK, 8'h00, 8'h00, 1'b0));
    endtask

    // Random traffic with occasional sleep, prescale and wake sequences.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(make_item(ACT_WRITE, ADDR_MODE1, 8'($urandom) | 8'h10, 1'b0));
                send_item(make_item(ACT_WRITE, PRESCALE_ADDR,
                                    $urandom_range(0, 1) ? 8'($urandom_range(0, 5))
                                                         : 8'($urandom), 1'b0));
                send_item(make_item(ACT_WRITE, ADDR_MODE1, 8'($urandom) & 8'hEF, 1'b0));
                sent += 3;
            end else begin
                send_item(random_item());
                sent++;
            end
        end
    endtask

    // The result side holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        in_idle_on = 1'b0;
        hold_len   = 200;
        for (int i = 0; i < 40; i++)
            send_item(random_item());
        in_idle_on = 1'b1;
    endtask

    // Full rate at the end: no idling on either side.
    task automatic test_full_rate();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        test_random_traffic(60);
    endtask

    initial begin : main
        int unsigned guard;
        shadow_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_register_rules();
        test_output_modes();
        test_random_traffic(330);
        test_backpressure();
        test_full_rate();
        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_outputs.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_outputs.size() != 0)
            note_error("results never delivered", 16'(pending_outputs.size()), 16'h0);
        if (err_count == 0)
            $display("tb_sixteen_channel_pwm_register_block_core OK");
        else
            $display("tb_sixteen_channel_pwm_register_block_core NOT OK");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin : watchdog
        #2000000;
        $display("tb_sixteen_channel_pwm_register_block_core NOT OK");
        $finish;
    end

endmodule

FILE: files.f
src/pwmrb_pkg.sv
src/pwmrb_ctrl.sv
src/pwmrb_dp.sv
src/sixteen_channel_pwm_register_block_core.sv
bench/tb_sixteen_channel_pwm_register_block_core.sv
